/* rtl/dtq_pkg.sv */
// ----------------------------------------------------------------------------
// dtq_pkg
// Types and codes shared by the deadline task queue and its checker.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam logic [1:0] OP_ONCE     = 2'd0;
  localparam logic [1:0] OP_PERIODIC = 2'd1;
  localparam logic [1:0] OP_RUN      = 2'd2;

  localparam logic [31:0] IDLE_WAIT_RESET = 32'd1000;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  task_id;
    logic [31:0] amount_ms;
    logic        needs_device;
    logic [31:0] now_ms;
    logic        device_on;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  due_task;
    logic        ran;
    logic [31:0] wait_ms;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0] deadline;
    logic [31:0] interval;
    logic [3:0]  task_id;
    logic        periodic;
    logic        needs_device;
  } entry_t;

endpackage

/* rtl/deadline_task_queue.sv */
// ----------------------------------------------------------------------------
// deadline_task_queue
// Sorted timer queue held in a position-ordered entry memory.
// ----------------------------------------------------------------------------
// One request at a time. A schedule scans the entries to find the task,
// moves the entries behind it forward to close its old slot, and moves
// entries with later deadlines up one slot to open the new one. The scan and
// the close together cover the queue once. A run copies each due entry to
// the due buffer, slides the remaining entries forward, then dispatches
// each due entry, with a sorted reinsertion for periodic ones, and ends
// with the wait report. The single read port of the entry memory sets the
// pace of all of these. No clearing pass is needed after reset.
module deadline_task_queue #(
  parameter int TASK_SLOTS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dtq_pkg::req_t  in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output dtq_pkg::res_t  out_res,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [31:0]    cfg_data
);
  import dtq_pkg::*;

  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [CW:0] SLOTS = (CW + 1)'(TASK_SLOTS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FIND_RD = 4'd1;
  localparam logic [3:0] S_FIND_CK = 4'd2;
  localparam logic [3:0] S_REM_RD  = 4'd3;
  localparam logic [3:0] S_REM_WR  = 4'd4;
  localparam logic [3:0] S_INS_GO  = 4'd5;
  localparam logic [3:0] S_INS_RD  = 4'd6;
  localparam logic [3:0] S_INS_CK  = 4'd7;
  localparam logic [3:0] S_DUE_RD  = 4'd8;
  localparam logic [3:0] S_DUE_CK  = 4'd9;
  localparam logic [3:0] S_SHF_RD  = 4'd10;
  localparam logic [3:0] S_SHF_WR  = 4'd11;
  localparam logic [3:0] S_DSP_RD  = 4'd12;
  localparam logic [3:0] S_DSP_CK  = 4'd13;
  localparam logic [3:0] S_WAIT_RD = 4'd14;
  localparam logic [3:0] S_WAIT_CK = 4'd15;

  logic [3:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] due, due_next;
  logic [CW-1:0] bidx, bidx_next;
  logic [31:0]   idle_wait;
  req_t          req;
  entry_t        ins, ins_next;
  res_t          res_next;
  logic          emit;

  logic          m_we, b_we;
  logic [IW-1:0] m_waddr, m_raddr, b_raddr;
  entry_t        m_wdata, m_rdata, b_rdata;

  logic [CW:0]   idx_up, idx_due;
  logic          can_emit;

  dtq_ram #(.DEPTH(TASK_SLOTS), .AW(IW)) u_queue (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  // Holds the entries popped by a run while the queue is rebuilt.
  dtq_ram #(.DEPTH(TASK_SLOTS), .AW(IW)) u_due (
    .clk(clk), .we(b_we), .waddr(idx[IW-1:0]), .wdata(m_rdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign idx_up    = {1'b0, idx} + 1'b1;
  assign idx_due   = {1'b0, idx} + {1'b0, due};
  assign can_emit  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    due_next   = due;
    bidx_next  = bidx;
    ins_next   = ins;
    m_we       = 1'b0;
    m_waddr    = idx[IW-1:0];
    m_wdata    = m_rdata;
    m_raddr    = idx[IW-1:0];
    b_we       = 1'b0;
    b_raddr    = bidx[IW-1:0];
    emit       = 1'b0;
    res_next   = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          idx_next = '0;
          ins_next.task_id      = in_req.task_id;
          ins_next.needs_device = in_req.needs_device;
          ins_next.periodic     = (in_req.op == OP_PERIODIC);
          ins_next.interval     = (in_req.op == OP_PERIODIC) ? in_req.amount_ms : 32'd0;
          ins_next.deadline     = (in_req.op == OP_PERIODIC) ? in_req.now_ms
                                  : in_req.now_ms + in_req.amount_ms;
          if (in_req.op == OP_ONCE || in_req.op == OP_PERIODIC) begin
            state_next = S_FIND_RD;
          end else if (in_req.op == OP_RUN) begin
            state_next = S_DUE_RD;
          end
        end
      end
      S_FIND_RD: begin
        state_next = (idx < count) ? S_FIND_CK : S_INS_GO;
      end
      S_FIND_CK: begin
        if (m_rdata.task_id == req.task_id) begin
          state_next = S_REM_RD;
        end else begin
          idx_next   = idx_up[CW-1:0];
          state_next = S_FIND_RD;
        end
      end
      S_REM_RD: begin
        m_raddr = idx_up[IW-1:0];
        if (idx_up < {1'b0, count}) begin
          state_next = S_REM_WR;
        end else begin
          count_next = count - 1'b1;
          state_next = S_INS_GO;
        end
      end
      S_REM_WR: begin
        m_we       = 1'b1;
        idx_next   = idx_up[CW-1:0];
        state_next = S_REM_RD;
      end
      S_INS_GO: begin
        if ({1'b0, count} >= SLOTS) begin
          state_next = (req.op == OP_RUN) ? S_DSP_RD : S_IDLE;
        end else begin
          idx_next   = count;
          state_next = S_INS_RD;
        end
      end
      S_INS_RD: begin
        // Walk from the tail, moving later deadlines up one slot.
        m_raddr = IW'(idx - 1'b1);
        if (idx == '0) begin
          m_we       = 1'b1;
          m_wdata    = ins;
          count_next = count + 1'b1;
          state_next = (req.op == OP_RUN) ? S_DSP_RD : S_IDLE;
        end else begin
          state_next = S_INS_CK;
        end
      end
      S_INS_CK: begin
        m_we = 1'b1;
        if (m_rdata.deadline > ins.deadline) begin
          idx_next   = idx - 1'b1;
          state_next = S_INS_RD;
        end else begin
          m_wdata    = ins;
          count_next = count + 1'b1;
          state_next = (req.op == OP_RUN) ? S_DSP_RD : S_IDLE;
        end
      end
      S_DUE_RD: begin
        if (idx < count) begin
          state_next = S_DUE_CK;
        end else begin
          due_next   = idx;
          idx_next   = '0;
          state_next = S_SHF_RD;
        end
      end
      S_DUE_CK: begin
        if (m_rdata.deadline <= req.now_ms) begin
          b_we       = 1'b1;
          idx_next   = idx_up[CW-1:0];
          state_next = S_DUE_RD;
        end else begin
          due_next   = idx;
          idx_next   = '0;
          state_next = S_SHF_RD;
        end
      end
      S_SHF_RD: begin
        m_raddr = idx_due[IW-1:0];
        if (idx_due < {1'b0, count}) begin
          state_next = S_SHF_WR;
        end else begin
          count_next = count - due;
          bidx_next  = '0;
          state_next = S_DSP_RD;
        end
      end
      S_SHF_WR: begin
        m_we       = 1'b1;
        idx_next   = idx_up[CW-1:0];
        state_next = S_SHF_RD;
      end
      S_DSP_RD: begin
        if (bidx < due) begin
          state_next = S_DSP_CK;
        end else begin
          idx_next   = '0;
          state_next = S_WAIT_RD;
        end
      end
      S_DSP_CK: begin
        if (can_emit) begin
          emit              = 1'b1;
          res_next.due_task = b_rdata.task_id;
          res_next.ran      = req.device_on || !b_rdata.needs_device;
          bidx_next         = bidx + 1'b1;
          if (b_rdata.periodic) begin
            ins_next          = b_rdata;
            ins_next.deadline = req.now_ms + b_rdata.interval;
            state_next        = S_INS_GO;
          end else begin
            state_next = S_DSP_RD;
          end
        end
      end
      S_WAIT_RD: begin
        state_next = S_WAIT_CK;
      end
      S_WAIT_CK: begin
        if (can_emit) begin
          emit          = 1'b1;
          res_next.kind = 1'b1;
          res_next.last = 1'b1;
          if (count == '0) begin
            res_next.wait_ms = idle_wait;
          end else if (m_rdata.deadline > req.now_ms) begin
            res_next.wait_ms = m_rdata.deadline - req.now_ms;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      idle_wait <= IDLE_WAIT_RESET;
    end else begin
      state <= state_next;
      count <= count_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        idle_wait <= cfg_data;
      end
    end
    idx  <= idx_next;
    due  <= due_next;
    bidx <= bidx_next;
    ins  <= ins_next;
    if (emit) begin
      out_res <= res_next;
    end
    if (in_valid && in_ready) begin
      req <= in_req;
    end
  end

endmodule

/* rtl/dtq_ram.sv */
// ----------------------------------------------------------------------------
// dtq_ram
// Entry memory: one write port, one registered read port, write forwarding.
// ----------------------------------------------------------------------------
module dtq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  dtq_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output dtq_pkg::entry_t rdata
);
  import dtq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/dtq_checker.sv */
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks on the deadline task queue, bound to the top level.
// ----------------------------------------------------------------------------
module dtq_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input dtq_pkg::req_t in_req,
  input logic          out_valid,
  input logic          out_ready,
  input dtq_pkg::res_t out_res
);
  import dtq_pkg::*;

  // A held result must not change under backpressure.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("result changed while stalled");

  a_wait_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.kind |-> out_res.last && out_res.due_task == 4'd0 && !out_res.ran)
    else $error("malformed wait report");

  a_dispatch_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.kind |-> !out_res.last && out_res.wait_ms == 32'd0)
    else $error("malformed dispatch");

  // An accepted run request must always make the block busy; it stays busy until its report.
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_req.op == OP_RUN |=> !in_ready)
    else $error("run request finished without work");

endmodule

bind deadline_task_queue dtq_checker u_dtq_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
  .out_valid(out_valid), .out_ready(out_ready), .out_res(out_res)
);

/* tb/tb_deadline_task_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deadline_task_queue
// Drives schedule and run requests into the deadline task queue, predicts
// every dispatch and wait report, and compares them in order.
// ----------------------------------------------------------------------------
module tb_deadline_task_queue;
  import dtq_pkg::*;

  localparam int SLOTS = 16;
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  deadline_task_queue #(.TASK_SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(out_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the timer queue.
  entry_t timers[$];
  logic [31:0] idle_wait;
  res_t pending_results[$];
  int errors = 0;
  int quiet_cycles = 0;
  bit long_stalls = 1'b1;

  function automatic int gap_len();
    if (!long_stalls || $urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic void queue_timer(entry_t e);
    int pos;
    pos = 0;
    if (timers.size() >= SLOTS) return;
    while (pos < timers.size() && timers[pos].deadline <= e.deadline) pos++;
    timers.insert(pos, e);
  endfunction

  function automatic void predict_request(req_t r);
    entry_t e;
    entry_t due[$];
    res_t res;
    if (r.op == OP_ONCE || r.op == OP_PERIODIC) begin
      foreach (timers[i]) begin
        if (timers[i].task_id == r.task_id) begin
          timers.delete(i);
          break;
        end
      end
      e.task_id = r.task_id;
      e.needs_device = r.needs_device;
      e.periodic = (r.op == OP_PERIODIC);
      e.deadline = e.periodic ? r.now_ms : r.now_ms + r.amount_ms;
      e.interval = e.periodic ? r.amount_ms : 32'd0;
      queue_timer(e);
    end else if (r.op == OP_RUN) begin
      while (timers.size() > 0 && timers[0].deadline <= r.now_ms)
        due.push_back(timers.pop_front());
      foreach (due[i]) begin
        res = '0;
        res.due_task = due[i].task_id;
        res.ran = r.device_on || !due[i].needs_device;
        pending_results.push_back(res);
        if (due[i].periodic) begin
          e = due[i];
          e.deadline = r.now_ms + e.interval;
          queue_timer(e);
        end
      end
      res = '0;
      res.kind = 1'b1;
      res.last = 1'b1;
      if (timers.size() == 0) res.wait_ms = idle_wait;
      else if (timers[0].deadline <= r.now_ms) res.wait_ms = 32'd0;
      else res.wait_ms = timers[0].deadline - r.now_ms;
      pending_results.push_back(res);
    end
  endfunction

  // Result checker and receiver stalls.
  initial begin
    int g;
    res_t exp_res;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_res);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_res !== exp_res) begin
          $display("%0t: result mismatch expected %h actual %h (kind %0d/%0d task %0d/%0d "
                   , $time, exp_res, out_res, exp_res.kind, out_res.kind,
                   exp_res.due_task, out_res.due_task);
          $display("%0t:   ran %0d/%0d wait %0d/%0d last %0d/%0d", $time, exp_res.ran,
                   out_res.ran, exp_res.wait_ms, out_res.wait_ms, exp_res.last,
                   out_res.last);
          errors++;
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog on cycles without any accepted handshake.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("tb_deadline_task_queue NOT OK");
      $finish;
    end
  end

  // Valid stays high into the next request when there is no gap; drain()
  // lowers it once a test is done sending.
  task automatic send_request(req_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_req <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(r);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_idle_wait(logic [31:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    idle_wait = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t make_req(logic [1:0] op, logic [3:0] t, logic [31:0] amt,
                                    logic nd, logic [31:0] now, logic dev);
    req_t r;
    r.op = op; r.task_id = t; r.amount_ms = amt; r.needs_device = nd;
    r.now_ms = now; r.device_on = dev;
    return r;
  endfunction

  task automatic test_directed();
    send_request(make_req(OP_RUN, 4'hF, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0));
    send_request(make_req(OP_ONCE, 4'd0, 32'd0, 1'b0, 32'd10, 1'b1));
    send_request(make_req(OP_ONCE, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'd10, 1'b0));
    send_request(make_req(OP_PERIODIC, 4'd3, 32'd0, 1'b1, 32'd5, 1'b1));
    send_request(make_req(OP_PERIODIC, 4'd4, 32'd7, 1'b0, 32'd5, 1'b0));
    send_request(make_req(2'd3, 4'd9, 32'd1, 1'b1, 32'd1, 1'b1));
    send_request(make_req(OP_RUN, 4'd0, 32'd0, 1'b0, 32'd10, 1'b0));
    send_request(make_req(OP_RUN, 4'd0, 32'd0, 1'b0, 32'd12, 1'b1));
    // Reschedule an already queued task, then let a deadline wrap past zero.
    send_request(make_req(OP_ONCE, 4'd4, 32'd3, 1'b0, 32'd12, 1'b0));
    send_request(make_req(OP_PERIODIC, 4'd5, 32'h8000_0000, 1'b1, 32'hFFFF_FFF0, 1'b0));
    send_request(make_req(OP_RUN, 4'd0, 32'd0, 1'b0, 32'hFFFF_FFFF, 1'b1));
    send_request(make_req(OP_RUN, 4'd0, 32'd0, 1'b0, 32'd20, 1'b0));
    // Fill every slot, then run with every entry due.
    for (int i = 0; i < SLOTS; i++)
      send_request(make_req(OP_ONCE, 4'(i), 32'd100, 1'(i), 32'd30, 1'b0));
    send_request(make_req(OP_RUN, 4'd0, 32'd0, 1'b0, 32'd200, 1'b0));
  endtask

  task automatic test_random(int n, int tmax);
    req_t r;
    logic [31:0] clock_ms;
    clock_ms = $urandom();
    for (int i = 0; i < n; i++) begin
      r = make_req(2'($urandom_range(0, 2)), 4'($urandom_range(0, tmax)), 32'd0,
                   1'($urandom), clock_ms, 1'($urandom));
      case ($urandom_range(0, 5))
        0: r.amount_ms = $urandom();
        1: r.amount_ms = 32'd0;
        default: r.amount_ms = $urandom_range(1, 40);
      endcase
      if ($urandom_range(0, 19) == 0) r.op = 2'd3;
      if ($urandom_range(0, 15) == 0) r.now_ms = $urandom();
      send_request(r);
      clock_ms = clock_ms + $urandom_range(0, 15);
    end
  endtask

  initial begin
    idle_wait = IDLE_WAIT_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    write_idle_wait(32'hFFFF_FFFF);
    test_random(50, 15);
    write_idle_wait(32'd0);
    long_stalls = 1'b0;
    test_random(30, 5);
    long_stalls = 1'b1;
    write_idle_wait($urandom());
    test_random(50, 15);
    drain();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_deadline_task_queue OK");
    end else begin
      $display("tb_deadline_task_queue NOT OK");
    end
    $finish;
  end

endmodule
